### src/hct_pkg.sv
// Shared types, constants and helpers for the HTML chunk tokenizer.
// No dependencies; every other file reaches into this package by scoped names.
package hct_pkg;

  localparam int OFF_W  = 24;
  localparam int LINE_W = 20;
  localparam int KIND_W = 3;

  // Result queue depth; at most two results come from one byte.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Chunk kinds
  localparam logic [KIND_W-1:0] KIND_SPACE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OPEN    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SELF    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLOSE   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_COMMENT = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DOCTYPE = 3'd6;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd7;

  // Byte codes
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UPD   = 8'h44;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Prefix lengths and the index reached right after "<!"
  localparam logic [3:0] COM_LEN   = 4'd4;
  localparam logic [3:0] DOC_LEN   = 4'd9;
  localparam logic [3:0] BANG_IDX  = 4'd2;
  localparam logic [3:0] AFTER_BANG = 4'd3;

  typedef enum logic [10:0] {
    PH_IDLE    = 11'b000_0000_0001,
    PH_SPACE   = 11'b000_0000_0010,
    PH_LT      = 11'b000_0000_0100,
    PH_BANG    = 11'b000_0000_1000,
    PH_PRECOM  = 11'b000_0001_0000,
    PH_COMMENT = 11'b000_0010_0000,
    PH_PREDOC  = 11'b000_0100_0000,
    PH_DOCTYPE = 11'b000_1000_0000,
    PH_CLOSE   = 11'b001_0000_0000,
    PH_OPEN    = 11'b010_0000_0000,
    PH_SKIP    = 11'b100_0000_0000
  } hct_phase_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  start;
    logic [OFF_W-1:0]  length;
    logic [LINE_W-1:0] line;
    logic              done;
  } hct_result_t;

  // Up to two results per accepted byte, slot a first in order.
  typedef struct packed {
    logic        a_vld;
    hct_result_t a;
    logic        b_vld;
    hct_result_t b;
  } hct_push_t;

  function automatic logic [7:0] com_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_LT;
      2'd1:    c = CH_BANG;
      default: c = CH_DASH;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] doc_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = CH_LT;
      4'd1:    c = CH_BANG;
      4'd2:    c = CH_UPD;
      4'd3:    c = 8'h4F;
      4'd4:    c = 8'h43;
      4'd5:    c = 8'h54;
      4'd6:    c = 8'h59;
      4'd7:    c = 8'h50;
      4'd8:    c = 8'h45;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [OFF_W-1:0] sat_off(input logic [OFF_W-1:0] v);
    return (&v) ? v : v + OFF_W'(1);
  endfunction

  function automatic logic [LINE_W-1:0] sat_line(input logic [LINE_W-1:0] v);
    return (&v) ? v : v + LINE_W'(1);
  endfunction

endpackage

### src/hct_scanner.sv
// Byte scanner: phase machine, offsets, line counts and chunk bookkeeping.
// Depends on hct_pkg; produces up to two results per accepted byte.
module hct_scanner (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         data_byte,
  input  logic               is_last,
  output hct_pkg::hct_push_t push
);

  hct_pkg::hct_phase_t            phase_r, phase_nxt;
  logic [hct_pkg::OFF_W-1:0]      off_r, off_nxt;
  logic [hct_pkg::OFF_W-1:0]      begin_r, begin_nxt;
  logic [hct_pkg::OFF_W-1:0]      count_r, count_nxt;
  logic [hct_pkg::LINE_W-1:0]     line_r, line_nxt;
  logic [hct_pkg::LINE_W-1:0]     cline_r, cline_nxt;
  logic [3:0]                     pidx_r, pidx_nxt;
  logic [1:0]                     dash_r, dash_nxt;
  logic                           slash_r, slash_nxt;
  logic                           text_r, text_nxt;

  // Working values once the chunk start has been settled for this byte
  hct_pkg::hct_phase_t            ph_w;
  logic [hct_pkg::OFF_W-1:0]      begin_w, count_w;
  logic [hct_pkg::LINE_W-1:0]     cline_w;
  logic [3:0]                     pidx_w;
  logic [1:0]                     dash_w;
  logic                           slash_w, text_w;
  logic                           flush, fresh, err, tag_end, restart, above_sp;
  logic [hct_pkg::KIND_W-1:0]     tag_kind;

  assign above_sp = data_byte > hct_pkg::CH_SPACE;

  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    begin_nxt = begin_r;
    count_nxt = count_r;
    line_nxt  = line_r;
    cline_nxt = cline_r;
    pidx_nxt  = pidx_r;
    dash_nxt  = dash_r;
    slash_nxt = slash_r;
    text_nxt  = text_r;
    push      = '0;
    restart   = 1'b0;
    err       = 1'b0;
    tag_end   = 1'b0;
    tag_kind  = hct_pkg::KIND_OPEN;

    // Text or space chunk closes on '<'
    flush = (phase_r == hct_pkg::PH_SPACE) && (data_byte == hct_pkg::CH_LT);
    fresh = flush || (phase_r == hct_pkg::PH_IDLE);

    push.a.kind   = text_r ? hct_pkg::KIND_TEXT : hct_pkg::KIND_SPACE;
    push.a.start  = begin_r;
    push.a.length = count_r;
    push.a.line   = cline_r;
    push.a.done   = 1'b0;

    if (fresh) begin
      begin_w = off_r;
      cline_w = line_r;
      count_w = hct_pkg::OFF_W'(1);
      pidx_w  = '0;
      dash_w  = '0;
      slash_w = 1'b0;
      text_w  = above_sp && (data_byte != hct_pkg::CH_LT);
      ph_w    = (data_byte == hct_pkg::CH_LT) ? hct_pkg::PH_LT : hct_pkg::PH_SPACE;
    end else begin
      begin_w = begin_r;
      cline_w = cline_r;
      count_w = hct_pkg::sat_off(count_r);
      pidx_w  = pidx_r;
      dash_w  = dash_r;
      slash_w = slash_r;
      text_w  = text_r;
      ph_w    = phase_r;
      unique case (phase_r)
        hct_pkg::PH_SPACE: begin
          if (above_sp) text_w = 1'b1;
        end
        hct_pkg::PH_LT: begin
          if (data_byte == hct_pkg::CH_SLASH) begin
            ph_w = hct_pkg::PH_CLOSE;
          end else if (data_byte == hct_pkg::CH_BANG) begin
            ph_w   = hct_pkg::PH_BANG;
            pidx_w = hct_pkg::BANG_IDX;
          end else if (data_byte == hct_pkg::CH_GT) begin
            tag_end  = 1'b1;
            tag_kind = hct_pkg::KIND_OPEN;
            ph_w     = hct_pkg::PH_IDLE;
          end else begin
            ph_w = hct_pkg::PH_OPEN;
            if (above_sp) slash_w = (data_byte == hct_pkg::CH_SLASH);
          end
        end
        hct_pkg::PH_OPEN: begin
          if (data_byte == hct_pkg::CH_GT) begin
            tag_end  = 1'b1;
            tag_kind = slash_r ? hct_pkg::KIND_SELF : hct_pkg::KIND_OPEN;
            ph_w     = hct_pkg::PH_IDLE;
          end else if (above_sp) begin
            slash_w = (data_byte == hct_pkg::CH_SLASH);
          end
        end
        hct_pkg::PH_CLOSE: begin
          if (data_byte == hct_pkg::CH_GT) begin
            tag_end  = 1'b1;
            tag_kind = hct_pkg::KIND_CLOSE;
            ph_w     = hct_pkg::PH_IDLE;
          end
        end
        hct_pkg::PH_BANG: begin
          pidx_w = hct_pkg::AFTER_BANG;
          if (data_byte == hct_pkg::CH_DASH) ph_w = hct_pkg::PH_PRECOM;
          else if (data_byte == hct_pkg::CH_UPD) ph_w = hct_pkg::PH_PREDOC;
          else err = 1'b1;
        end
        hct_pkg::PH_PRECOM: begin
          if ((pidx_r < hct_pkg::COM_LEN) &&
              (data_byte == hct_pkg::com_char(pidx_r[1:0]))) begin
            pidx_w = pidx_r + 4'd1;
            if (pidx_w == hct_pkg::COM_LEN) begin
              ph_w   = hct_pkg::PH_COMMENT;
              dash_w = '0;
            end
          end else begin
            err = 1'b1;
          end
        end
        hct_pkg::PH_PREDOC: begin
          if ((pidx_r < hct_pkg::DOC_LEN) &&
              (data_byte == hct_pkg::doc_char(pidx_r))) begin
            pidx_w = pidx_r + 4'd1;
            if (pidx_w == hct_pkg::DOC_LEN) ph_w = hct_pkg::PH_DOCTYPE;
          end else begin
            err = 1'b1;
          end
        end
        hct_pkg::PH_COMMENT: begin
          if ((data_byte == hct_pkg::CH_GT) && (&dash_r)) begin
            tag_end  = 1'b1;
            tag_kind = hct_pkg::KIND_COMMENT;
            ph_w     = hct_pkg::PH_IDLE;
          end else begin
            dash_w = {dash_r[0], data_byte == hct_pkg::CH_DASH};
          end
        end
        hct_pkg::PH_DOCTYPE: begin
          if (data_byte == hct_pkg::CH_GT) begin
            tag_end  = 1'b1;
            tag_kind = hct_pkg::KIND_DOCTYPE;
            ph_w     = hct_pkg::PH_IDLE;
          end
        end
        default: err = 1'b1;
      endcase
    end

    // Second result slot: tag end, error, or end-of-document flush
    push.b.start  = begin_w;
    push.b.length = count_w;
    push.b.line   = cline_w;
    push.b.done   = err || is_last;
    if (tag_end) push.b.kind = tag_kind;
    else if (!err && (ph_w == hct_pkg::PH_SPACE))
      push.b.kind = text_w ? hct_pkg::KIND_TEXT : hct_pkg::KIND_SPACE;
    else push.b.kind = hct_pkg::KIND_ERROR;

    if (take) begin
      if (phase_r == hct_pkg::PH_SKIP) begin
        // Drop the rest of a failed document
        restart = is_last;
      end else begin
        push.a_vld = flush;
        push.b_vld = tag_end || err || (is_last && (ph_w != hct_pkg::PH_IDLE));
        if (err) begin
          phase_nxt = hct_pkg::PH_SKIP;
          restart   = is_last;
        end else begin
          phase_nxt = ph_w;
          begin_nxt = begin_w;
          count_nxt = count_w;
          cline_nxt = cline_w;
          pidx_nxt  = pidx_w;
          dash_nxt  = dash_w;
          slash_nxt = slash_w;
          text_nxt  = text_w;
          off_nxt   = hct_pkg::sat_off(off_r);
          if (data_byte == hct_pkg::CH_NL) line_nxt = hct_pkg::sat_line(line_r);
          restart   = is_last;
        end
      end
    end

    if (restart) begin
      phase_nxt = hct_pkg::PH_IDLE;
      off_nxt   = '0;
      begin_nxt = '0;
      count_nxt = '0;
      line_nxt  = hct_pkg::LINE_W'(1);
      cline_nxt = hct_pkg::LINE_W'(1);
      pidx_nxt  = '0;
      dash_nxt  = '0;
      slash_nxt = 1'b0;
      text_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hct_pkg::PH_IDLE;
      off_r   <= '0;
      begin_r <= '0;
      count_r <= '0;
      line_r  <= hct_pkg::LINE_W'(1);
      cline_r <= hct_pkg::LINE_W'(1);
      pidx_r  <= '0;
      dash_r  <= '0;
      slash_r <= 1'b0;
      text_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      begin_r <= begin_nxt;
      count_r <= count_nxt;
      line_r  <= line_nxt;
      cline_r <= cline_nxt;
      pidx_r  <= pidx_nxt;
      dash_r  <= dash_nxt;
      slash_r <= slash_nxt;
      text_r  <= text_nxt;
    end
  end

endmodule

### src/hct_out_fifo.sv
// Result queue: takes up to two results a cycle, hands out one per transaction.
// Depends on hct_pkg for the result types and queue depth.
module hct_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hct_pkg::hct_push_t   push,
  input  logic                 pop,
  output hct_pkg::hct_result_t head,
  output logic                 head_vld,
  output logic                 room
);

  hct_pkg::hct_result_t        entry_r [hct_pkg::QDEPTH];
  logic [hct_pkg::QPTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt, wp_b;
  logic [hct_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt, n_push;
  logic                        do_pop;

  assign head     = entry_r[rp_r];
  assign head_vld = (cnt_r != '0);
  // Keep space for a two-result byte so acceptance never looks at out_ready
  assign room     = (cnt_r <= hct_pkg::QCNT_W'(hct_pkg::QDEPTH - 2));
  assign do_pop   = pop && head_vld;

  always_comb begin
    n_push  = hct_pkg::QCNT_W'(push.a_vld) + hct_pkg::QCNT_W'(push.b_vld);
    wp_b    = wp_r + hct_pkg::QPTR_W'(push.a_vld);
    wp_nxt  = wp_r + hct_pkg::QPTR_W'(n_push);
    rp_nxt  = rp_r + hct_pkg::QPTR_W'(do_pop);
    cnt_nxt = cnt_r + n_push - hct_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.a_vld) entry_r[wp_r] <= push.a;
    if (push.b_vld) entry_r[wp_b] <= push.b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### src/html_chunk_tokenizer.sv
// Each result is registered into the result queue from the byte that closes its chunk.
// One byte per cycle while in_ready is high; a byte that yields two results is still
// one transfer in, and the four-entry result queue drains one result per transaction.
// in_ready drops only while the result queue holds more than two results.
// Reset (rst_n low, synchronous): scanner back to idle, offset 0, line 1, queue empty.
module html_chunk_tokenizer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_is_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hct_pkg::KIND_W-1:0]  out_chunk_kind,
  output logic [hct_pkg::OFF_W-1:0]   out_chunk_start,
  output logic [hct_pkg::OFF_W-1:0]   out_chunk_length,
  output logic [hct_pkg::LINE_W-1:0]  out_start_line,
  output logic                        out_doc_done
);

  hct_pkg::hct_push_t   push;
  hct_pkg::hct_result_t head;
  logic                 take;

  // Accept a transaction whenever the queue can absorb two results
  assign take = in_valid && in_ready;

  // Scan the byte and form this byte's results in the same cycle
  hct_scanner u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .is_last   (in_is_last),
    .push      (push)
  );

  // Hold results until the consumer takes them, in order
  hct_out_fifo u_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (out_ready),
    .head     (head),
    .head_vld (out_valid),
    .room     (in_ready)
  );

  assign out_chunk_kind   = head.kind;
  assign out_chunk_start  = head.start;
  assign out_chunk_length = head.length;
  assign out_start_line   = head.line;
  assign out_doc_done     = head.done;

endmodule

### src/hct_checker.sv
// Port-level checks for the HTML chunk tokenizer, bound to the top level.
// Depends on hct_pkg for widths and kind codes.
module hct_port_asserts (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hct_pkg::KIND_W-1:0]  out_chunk_kind,
  input logic [hct_pkg::OFF_W-1:0]   out_chunk_length,
  input logic [hct_pkg::LINE_W-1:0]  out_start_line,
  input logic                        out_doc_done
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // An error always ends its document
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_chunk_kind == hct_pkg::KIND_ERROR) |-> out_doc_done)
    else $error("error result without doc_done");

  // Every chunk covers at least one byte
  a_len_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_chunk_length != '0))
    else $error("empty chunk reported");

  // Lines count from one
  a_line_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_start_line != '0))
    else $error("start line of zero");

endmodule

bind html_chunk_tokenizer hct_port_asserts u_hct_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_chunk_kind   (out_chunk_kind),
  .out_chunk_length (out_chunk_length),
  .out_start_line   (out_start_line),
  .out_doc_done     (out_doc_done)
);
